FILE: rtl/pfp_pkg.sv
// Shared types, constants and the halving function for the posture frame parser.
`default_nettype none
package pfp_pkg;
  localparam logic [7:0] HDR_FIRST = 8'h0D;
  localparam logic [7:0] HDR_SECOND = 8'h0A;
  localparam int unsigned PAYLOAD_LEN = 24;
  localparam int unsigned IDX_W = 5;

  typedef enum logic [2:0] {
    PH_HUNT_CR = 3'd0,
    PH_HUNT_LF = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_TRL_LF  = 3'd3,
    PH_TRL_CR  = 3'd4
  } phase_t;

  // One classified byte handed from the front to the back.
  typedef struct packed {
    logic       store;
    logic [IDX_W-1:0] idx;
    logic       emit;
    logic [7:0] data;
  } cmd_t;

  // Halving of an IEEE-754 single bit pattern, rounding ties to even.
  function automatic logic [31:0] halve_bits(input logic [31:0] w);
    logic [7:0]  expo;
    logic [23:0] sig;
    logic [22:0] q;
    logic [31:0] r;
    expo = w[30:23];
    sig = {(expo == 8'd1), w[22:0]};
    q = sig[23:1];
    if (sig[0] && q[0]) begin
      q = q + 23'd1;
    end
    if (expo == 8'hFF) begin
      r = w;
    end else if (expo >= 8'd2) begin
      r = w - 32'h0080_0000;
    end else begin
      r = {w[31], 8'd0, q};
      if (sig[0] && sig[23:1] == 23'h7F_FFFF) begin
        r = {w[31], 8'd1, 23'd0};
      end
    end
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/pfp_front.sv
// Front part: frame state machine that classifies each received byte.
`default_nettype none
module pfp_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 rx_valid,
  output logic                rx_ready,
  input  wire  [7:0]          rx_byte,
  output logic                cmd_valid,
  input  wire                 cmd_ready,
  output pfp_pkg::cmd_t       cmd
);
  pfp_pkg::phase_t phase, phase_next;
  logic [pfp_pkg::IDX_W-1:0] idx, idx_next;
  logic fire;

  assign rx_ready = cmd_ready;
  assign cmd_valid = rx_valid;
  assign fire = rx_valid && cmd_ready;

  always_comb begin
    phase_next = phase;
    idx_next = idx;
    case (phase)
      pfp_pkg::PH_HUNT_CR: begin
        phase_next = (rx_byte == pfp_pkg::HDR_FIRST) ? pfp_pkg::PH_HUNT_LF
                                                     : pfp_pkg::PH_HUNT_CR;
      end
      pfp_pkg::PH_HUNT_LF: begin
        if (rx_byte == pfp_pkg::HDR_SECOND) begin
          idx_next = '0;
          phase_next = pfp_pkg::PH_PAYLOAD;
        end else if (rx_byte != pfp_pkg::HDR_FIRST) begin
          phase_next = pfp_pkg::PH_HUNT_CR;
        end
      end
      pfp_pkg::PH_PAYLOAD: begin
        if (idx >= pfp_pkg::IDX_W'(pfp_pkg::PAYLOAD_LEN - 1)) begin
          idx_next = '0;
          phase_next = pfp_pkg::PH_TRL_LF;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      pfp_pkg::PH_TRL_LF: begin
        phase_next = (rx_byte == pfp_pkg::HDR_SECOND) ? pfp_pkg::PH_TRL_CR
                                                      : pfp_pkg::PH_HUNT_CR;
      end
      default: phase_next = pfp_pkg::PH_HUNT_CR;
    endcase
  end

  always_comb begin
    cmd.data = rx_byte;
    cmd.idx = idx;
    cmd.store = (phase == pfp_pkg::PH_PAYLOAD) &&
                (idx < pfp_pkg::IDX_W'(pfp_pkg::PAYLOAD_LEN));
    cmd.emit = (phase == pfp_pkg::PH_TRL_CR) && (rx_byte == pfp_pkg::HDR_FIRST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= pfp_pkg::PH_HUNT_CR;
      idx <= '0;
    end else if (fire) begin
      phase <= phase_next;
      idx <= idx_next;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/pfp_queue.sv
// Two-entry queue between front and back.
`default_nettype none
module pfp_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  input  pfp_pkg::cmd_t  in_cmd,
  output logic           out_valid,
  input  wire            out_ready,
  output pfp_pkg::cmd_t  out_cmd
);
  pfp_pkg::cmd_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> !out_valid)
    else $error("valid from empty queue");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue push lost");
endmodule
`default_nettype wire

FILE: rtl/pfp_back.sv
// Back part: payload store and result register.
`default_nettype none
module pfp_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  input  pfp_pkg::cmd_t  cmd,
  output logic           out_valid,
  input  wire            out_ready,
  output logic [31:0]    z_angle,
  output logic [31:0]    x_angle,
  output logic [31:0]    y_angle,
  output logic [31:0]    position_x,
  output logic [31:0]    position_y,
  output logic [31:0]    yaw_rate
);
  logic [7:0] store [pfp_pkg::PAYLOAD_LEN];
  logic [31:0] words [6];
  logic take;

  // Accept a command unless a result is held and not taken, and an emit needs the register.
  assign cmd_ready = !out_valid || out_ready || !cmd.emit;
  assign take = cmd_valid && cmd_ready;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      words[k] = {store[4*k+3], store[4*k+2], store[4*k+1], store[4*k]};
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.store) begin
      store[cmd.idx] <= cmd.data;
    end
    if (take && cmd.emit) begin
      z_angle <= words[0];
      x_angle <= words[1];
      y_angle <= words[2];
      position_x <= pfp_pkg::halve_bits(words[3] ^ 32'h8000_0000);
      position_y <= pfp_pkg::halve_bits(words[4]);
      yaw_rate <= words[5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(position_x))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    !(take && cmd.store && cmd.emit))
    else $error("store and emit together");
endmodule
`default_nettype wire

FILE: rtl/posture_frame_parser_unit.sv
// Top level of the posture frame parser.
// Takes one received byte per cycle (rx_valid/rx_ready) and returns one
// six-word record per good frame (out_valid/out_ready). A frame is 0x0D 0x0A,
// 24 payload bytes, then 0x0A 0x0D; a mismatch drops back to header hunt.
// The front state machine classifies each byte combinationally; a two-entry
// queue carries it to the back, which writes the payload store or loads the
// result register. The last trailer byte passes through the queue, then the
// back registers out_valid. Bytes keep flowing while a result waits; only a
// second completed frame stalls until the first result is taken.
// position_x is word 3 with its sign flipped, then halved; position_y is
// word 4 halved (ties round to even); the other words pass unchanged.
`default_nettype none
module posture_frame_parser_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         rx_valid,
  output logic        rx_ready,
  input  wire  [7:0]  rx_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] z_angle,
  output logic [31:0] x_angle,
  output logic [31:0] y_angle,
  output logic [31:0] position_x,
  output logic [31:0] position_y,
  output logic [31:0] yaw_rate
);
  // front to queue
  logic          f_valid, f_ready;
  pfp_pkg::cmd_t f_cmd;
  // queue to back
  logic          b_valid, b_ready;
  pfp_pkg::cmd_t b_cmd;

  pfp_front u_front (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  pfp_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
    .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
  );

  pfp_back u_back (
    .clk(clk), .rst(rst),
    .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .z_angle(z_angle), .x_angle(x_angle), .y_angle(y_angle),
    .position_x(position_x), .position_y(position_y), .yaw_rate(yaw_rate)
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the posture frame parser unit.
`timescale 1ns / 100ps
`default_nettype none

typedef struct {
  logic [31:0] z_angle;
  logic [31:0] x_angle;
  logic [31:0] y_angle;
  logic [31:0] position_x;
  logic [31:0] position_y;
  logic [31:0] yaw_rate;
} posture_rec_t;

// Tracks the frame parser state and holds the records it should emit.
class posture_scoreboard;
  pfp_pkg::phase_t phase;
  logic [4:0] slot;
  logic [7:0] payload[24];
  posture_rec_t pending_recs[$];
  int errors;

  function new();
    phase = pfp_pkg::PH_HUNT_CR;
    slot = '0;
    errors = 0;
  endfunction

  // Halving of a single-precision bit pattern, rounding ties to even.
  function logic [31:0] half_of(logic [31:0] w);
    logic [7:0] ex;
    logic [23:0] sig;
    logic [31:0] q;
    ex = w[30:23];
    if (ex == 8'hFF) return w;
    if (ex >= 8'd2) return w - 32'h0080_0000;
    sig = (ex == 8'd1) ? {1'b1, w[22:0]} : {1'b0, w[22:0]};
    q = {9'd0, sig[23:1]};
    if (sig[0] && q[0]) q = q + 32'd1;
    return {w[31], 31'd0} | q;
  endfunction

  function logic [31:0] word_of(int k);
    return {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
  endfunction

  // Advance the frame state by one accepted byte.
  function void note_byte(logic [7:0] b);
    posture_rec_t r;
    case (phase)
      pfp_pkg::PH_HUNT_CR: phase = (b == pfp_pkg::HDR_FIRST) ? pfp_pkg::PH_HUNT_LF
                                                          : pfp_pkg::PH_HUNT_CR;
      pfp_pkg::PH_HUNT_LF: begin
        if (b == pfp_pkg::HDR_SECOND) begin
          slot = '0;
          phase = pfp_pkg::PH_PAYLOAD;
        end else if (b != pfp_pkg::HDR_FIRST) begin
          phase = pfp_pkg::PH_HUNT_CR;
        end
      end
      pfp_pkg::PH_PAYLOAD: begin
        payload[slot] = b;
        slot = slot + 5'd1;
        if (slot >= pfp_pkg::PAYLOAD_LEN) begin
          slot = '0;
          phase = pfp_pkg::PH_TRL_LF;
        end
      end
      pfp_pkg::PH_TRL_LF: phase = (b == pfp_pkg::HDR_SECOND) ? pfp_pkg::PH_TRL_CR
                                                          : pfp_pkg::PH_HUNT_CR;
      pfp_pkg::PH_TRL_CR: begin
        phase = pfp_pkg::PH_HUNT_CR;
        if (b == pfp_pkg::HDR_FIRST) begin
          r.z_angle = word_of(0);
          r.x_angle = word_of(1);
          r.y_angle = word_of(2);
          r.position_x = half_of(word_of(3) ^ 32'h8000_0000);
          r.position_y = half_of(word_of(4));
          r.yaw_rate = word_of(5);
          pending_recs.push_back(r);
        end
      end
      default: phase = pfp_pkg::PH_HUNT_CR;
    endcase
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_rec(posture_rec_t got);
    posture_rec_t e;
    if (pending_recs.size() == 0) begin
      report("unexpected record", got.z_angle, 32'd0);
      return;
    end
    e = pending_recs.pop_front();
    if (got.z_angle !== e.z_angle) report("z_angle", got.z_angle, e.z_angle);
    if (got.x_angle !== e.x_angle) report("x_angle", got.x_angle, e.x_angle);
    if (got.y_angle !== e.y_angle) report("y_angle", got.y_angle, e.y_angle);
    if (got.position_x !== e.position_x)
      report("position_x", got.position_x, e.position_x);
    if (got.position_y !== e.position_y)
      report("position_y", got.position_y, e.position_y);
    if (got.yaw_rate !== e.yaw_rate) report("yaw_rate", got.yaw_rate, e.yaw_rate);
  endtask
endclass

module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_valid = 1'b0;
  logic rx_ready;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] z_angle, x_angle, y_angle, position_x, position_y, yaw_rate;

  posture_scoreboard sb = new();
  logic [7:0] byte_stream[$];
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  posture_frame_parser_unit dut (
    .clk(clk), .rst(rst),
    .rx_valid(rx_valid), .rx_ready(rx_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .z_angle(z_angle), .x_angle(x_angle), .y_angle(y_angle),
    .position_x(position_x), .position_y(position_y), .yaw_rate(yaw_rate)
  );

  // Queue a complete, well-formed frame around the given payload words.
  task queue_frame(logic [31:0] w[6]);
    byte_stream.push_back(pfp_pkg::HDR_FIRST);
    byte_stream.push_back(pfp_pkg::HDR_SECOND);
    for (int k = 0; k < 6; k++)
      for (int j = 0; j < 4; j++) byte_stream.push_back(w[k][8*j +: 8]);
    byte_stream.push_back(pfp_pkg::HDR_SECOND);
    byte_stream.push_back(pfp_pkg::HDR_FIRST);
  endtask

  // Pick a float pattern that favors the halving corners.
  function logic [31:0] pick_float();
    logic [31:0] f;
    f = $urandom;
    case ($urandom_range(0, 5))
      0: f[30:23] = 8'd0;
      1: f[30:23] = 8'd1;
      2: f[30:23] = 8'hFF;
      3: f[30:23] = 8'd2;
      4: f[22:0] = $urandom_range(0, 1) ? 23'h7F_FFFF : 23'd1;
      default: ;
    endcase
    return f;
  endfunction

  task build_stimulus();
    logic [31:0] w[6];
    // Directed: halving corners, repeated header start, mismatches.
    w = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
          32'h0080_0001, 32'h00FF_FFFF, 32'h7FC0_0001};
    queue_frame(w);
    w = '{32'h7F80_0000, 32'h0000_0001, 32'h0080_0003,
          32'hFF80_0000, 32'h8000_0003, 32'h0100_0000};
    byte_stream.push_back(pfp_pkg::HDR_FIRST);  // repeated 0x0D before 0x0A
    queue_frame(w);
    w = '{32'h1, 32'h2, 32'h3, 32'h0000_0003, 32'h807F_FFFF, 32'h6};
    queue_frame(w);
    // Bad first trailer byte, then bad second trailer byte.
    byte_stream.push_back(pfp_pkg::HDR_FIRST);
    byte_stream.push_back(pfp_pkg::HDR_SECOND);
    repeat (24) byte_stream.push_back(8'h55);
    byte_stream.push_back(8'hAA);
    byte_stream.push_back(pfp_pkg::HDR_FIRST);
    byte_stream.push_back(pfp_pkg::HDR_SECOND);
    repeat (24) byte_stream.push_back(8'hAA);
    byte_stream.push_back(pfp_pkg::HDR_SECOND);
    byte_stream.push_back(8'h00);
    // Header broken after 0x0D.
    byte_stream.push_back(pfp_pkg::HDR_FIRST);
    byte_stream.push_back(8'hFF);
    // Random: mostly good frames, some noise and broken ones.
    while (byte_stream.size() < 1100) begin
      for (int k = 0; k < 6; k++) w[k] = pick_float();
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 8)) byte_stream.push_back(8'($urandom));
        1: begin
          queue_frame(w);
          byte_stream[byte_stream.size() - $urandom_range(1, 2)] = 8'($urandom);
        end
        default: queue_frame(w);
      endcase
    end
  endtask

  // Send bytes in bursts with random gaps.
  initial begin
    int burst;
    build_stimulus();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (byte_stream.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && byte_stream.size() > 0) begin
        rx_valid <= 1'b1;
        rx_byte <= byte_stream[0];
        @(posedge clk);
        if (rx_ready) begin
          sb.note_byte(byte_stream.pop_front());
          burst--;
        end
      end
      if (byte_stream.size() > 0 && $urandom_range(0, 2) != 0) begin
        rx_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    rx_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Stall the output on a pattern; once, hold off long enough to back up input.
  initial begin
    int n;
    n = 0;
    @(negedge rst);
    repeat (200) @(posedge clk);
    hold_off = 1'b1;
    out_ready <= 1'b0;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
    forever begin
      n++;
      out_ready <= (n % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
      @(posedge clk);
    end
  end

  // Check each transferred record and watch for a hang.
  initial begin
    posture_rec_t got;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{z_angle, x_angle, y_angle, position_x, position_y, yaw_rate};
        sb.check_rec(got);
      end
      if ((rx_valid && rx_ready) || (out_valid && out_ready) || hold_off)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > 2000) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Drain and finish.
  initial begin
    wait (stim_done);
    wait (sb.pending_recs.size() == 0);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: sim.f
rtl/pfp_pkg.sv
rtl/pfp_front.sv
rtl/pfp_queue.sv
rtl/pfp_back.sv
rtl/posture_frame_parser_unit.sv
tb/sv/tb.sv
